FILE: rtl/core/rmcb_pkg.sv
// Shared types, constants and box tables for the region mean color box classifier.
package rmcb_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned MEAN_W    = 8;
   localparam int unsigned NUM_CHAN  = 3;
   localparam int unsigned NUM_BOXES = 6;
   localparam int unsigned BOX_W     = 48;
   localparam int unsigned CLASS_W   = 3;
   localparam int unsigned BOX_IDX_W = 3;

   localparam logic [CLASS_W-1:0] CLASS_GREEN  = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_WHITE  = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_BLUE   = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_YELLOW = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_ORANGE = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_RED    = 3'd5;
   localparam logic [CLASS_W-1:0] CLASS_NONE   = 3'd6;

   typedef logic [BOX_W-1:0] box_type;

   // Boxes in scan order: blue, white, green, orange, yellow, red.
   localparam box_type BOX_RESET [NUM_BOXES] = '{
      48'd176566088771674, 48'd281474974407900, 48'd155029864473650,
      48'd281065525107230, 48'd281473712166400, 48'd280677966151680
   };

   localparam logic [CLASS_W-1:0] BOX_CLASS [NUM_BOXES] = '{
      CLASS_BLUE, CLASS_WHITE, CLASS_GREEN, CLASS_ORANGE, CLASS_YELLOW, CLASS_RED
   };

   typedef struct packed {
      logic [CHAN_W-1:0] pix_blue;
      logic [CHAN_W-1:0] pix_green;
      logic [CHAN_W-1:0] pix_red;
      logic              last_pixel;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean_blue;
      logic [MEAN_W-1:0]  mean_green;
      logic [MEAN_W-1:0]  mean_red;
      logic [CLASS_W-1:0] color_class;
      logic               region_overflow;
   } rsp_type;

   typedef struct packed {
      logic [BOX_IDX_W-1:0] reg_index;
      logic [BOX_W-1:0]     wdata;
   } csr_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_CLASSIFY,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/core/rmcb_chan_if.sv
// Valid/ready channel interface carrying one payload item per handshake.
interface rmcb_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

FILE: rtl/core/region_mean_color_box_classifier.sv
// Region mean color box classifier: accumulates a pixel region, divides, and classifies the mean.
// Pixels are accepted one per cycle while a region is being gathered, also while the previous
// result still waits on the response channel. The item marked last closes the region: the
// request channel then holds ready low through the bit-serial divider (one quotient bit per
// cycle on all three channels at once), the box scan (one box per cycle) and the load of the
// response register, plus any time spent waiting for the previous response to be taken.
// Pixels beyond MAX_PIXELS in a region are dropped and flagged.
module region_mean_color_box_classifier #(
   parameter int unsigned MAX_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   rmcb_chan_if.sink   req_ch,
   rmcb_chan_if.source rsp_ch,
   rmcb_chan_if.sink   csr_ch
);

   localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int unsigned SUM_W = CNT_W + rmcb_pkg::CHAN_W;

   rmcb_pkg::state_type state_ff, state_in;

   logic [rmcb_pkg::NUM_CHAN-1:0][SUM_W-1:0]             sum_ff, sum_in, sum_nx;
   logic [CNT_W-1:0]                                     count_ff, count_in, count_nx;
   logic                                                 ovf_ff, ovf_in, ovf_nx;
   logic                                                 ovf_hold_ff, ovf_hold_in;
   logic [rmcb_pkg::NUM_CHAN-1:0][rmcb_pkg::CHAN_W-1:0]  pix;
   logic                                                 room;
   logic                                                 req_fire;
   logic                                                 div_start;
   logic                                                 div_done;
   logic [rmcb_pkg::NUM_CHAN-1:0][rmcb_pkg::MEAN_W-1:0]  mean;

   rmcb_pkg::box_type                  box_ff [rmcb_pkg::NUM_BOXES];
   logic [rmcb_pkg::BOX_IDX_W-1:0]     box_idx_ff, box_idx_in;
   logic [rmcb_pkg::CLASS_W-1:0]       class_ff, class_in;
   rmcb_pkg::box_type                  box_sel;
   logic                               box_hit;
   logic                               scan_end;

   logic                               rsp_valid_ff, rsp_valid_in;
   rmcb_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic                               rsp_load;

   assign pix      = {req_ch.data.pix_red, req_ch.data.pix_green, req_ch.data.pix_blue};
   assign req_fire = req_ch.valid && req_ch.ready;
   assign room     = count_ff < CNT_W'(MAX_PIXELS);
   assign scan_end = box_idx_ff == rmcb_pkg::BOX_IDX_W'(rmcb_pkg::NUM_BOXES - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmcb_pkg::ST_ACCUM: begin
            if (req_fire && req_ch.data.last_pixel) begin
               state_in = rmcb_pkg::ST_DIVIDE;
            end
         end
         rmcb_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = rmcb_pkg::ST_CLASSIFY;
            end
         end
         rmcb_pkg::ST_CLASSIFY: begin
            if (scan_end) begin
               state_in = rmcb_pkg::ST_EMIT;
            end
         end
         rmcb_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = rmcb_pkg::ST_ACCUM;
            end
         end
         default: state_in = rmcb_pkg::ST_ACCUM;
      endcase
   end

   always_comb begin
      req_ch.ready = state_ff == rmcb_pkg::ST_ACCUM;
      csr_ch.ready = 1'b1;
      div_start    = req_fire && req_ch.data.last_pixel;
      rsp_load     = (state_ff == rmcb_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   always_comb begin
      for (int c = 0; c < rmcb_pkg::NUM_CHAN; c++) begin
         sum_nx[c] = room ? sum_ff[c] + SUM_W'(pix[c]) : sum_ff[c];
      end
      count_nx    = room ? count_ff + CNT_W'(1) : count_ff;
      ovf_nx      = ovf_ff || !room;
      sum_in      = sum_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      ovf_hold_in = ovf_hold_ff;
      if (req_fire) begin
         if (req_ch.data.last_pixel) begin
            sum_in      = '0;
            count_in    = '0;
            ovf_in      = 1'b0;
            ovf_hold_in = ovf_nx;
         end else begin
            sum_in   = sum_nx;
            count_in = count_nx;
            ovf_in   = ovf_nx;
         end
      end
   end

   rmcb_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_nx),
      .divisor  (count_nx),
      .quotient (mean),
      .done     (div_done)
   );

   always_comb begin
      box_sel = box_ff[box_idx_ff];
      box_hit = 1'b1;
      for (int c = 0; c < rmcb_pkg::NUM_CHAN; c++) begin
         if (mean[c] < box_sel[8*c +: 8] || mean[c] > box_sel[8*c + 24 +: 8]) begin
            box_hit = 1'b0;
         end
      end
      box_idx_in = box_idx_ff;
      class_in   = class_ff;
      if (state_ff == rmcb_pkg::ST_DIVIDE) begin
         box_idx_in = '0;
         class_in   = rmcb_pkg::CLASS_NONE;
      end else if (state_ff == rmcb_pkg::ST_CLASSIFY) begin
         box_idx_in = box_idx_ff + rmcb_pkg::BOX_IDX_W'(1);
         if (box_hit) begin
            class_in = rmcb_pkg::BOX_CLASS[box_idx_ff];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.mean_blue       = mean[0];
         rsp_data_in.mean_green      = mean[1];
         rsp_data_in.mean_red        = mean[2];
         rsp_data_in.color_class     = class_ff;
         rsp_data_in.region_overflow = ovf_hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmcb_pkg::ST_ACCUM;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rmcb_pkg::NUM_BOXES; i++) begin
            box_ff[i] <= rmcb_pkg::BOX_RESET[i];
         end
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready &&
             csr_ch.data.reg_index < rmcb_pkg::BOX_IDX_W'(rmcb_pkg::NUM_BOXES)) begin
            box_ff[csr_ch.data.reg_index] <= csr_ch.data.wdata;
         end
      end
      ovf_hold_ff <= ovf_hold_in;
      box_idx_ff  <= box_idx_in;
      class_ff    <= class_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

FILE: rtl/core/rmcb_divider.sv
// Three-lane restoring divider that produces one quotient bit per cycle.
module rmcb_divider #(
   parameter int unsigned SUM_W = 21,
   parameter int unsigned CNT_W = 13
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic [rmcb_pkg::NUM_CHAN-1:0][SUM_W-1:0]            dividend,
   input  logic [CNT_W-1:0]                                    divisor,
   output logic [rmcb_pkg::NUM_CHAN-1:0][rmcb_pkg::MEAN_W-1:0] quotient,
   output logic                                                done
);

   localparam int unsigned STEP_W = $clog2(rmcb_pkg::MEAN_W);

   logic                                                run_ff, run_in;
   logic [STEP_W-1:0]                                   step_ff, step_in;
   logic [SUM_W-1:0]                                    dsh_ff, dsh_in;
   logic [rmcb_pkg::NUM_CHAN-1:0][SUM_W-1:0]            rem_ff, rem_in;
   logic [rmcb_pkg::NUM_CHAN-1:0][rmcb_pkg::MEAN_W-1:0] quot_ff, quot_in;
   logic [rmcb_pkg::NUM_CHAN-1:0]                       ge;

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      dsh_in  = dsh_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      for (int c = 0; c < rmcb_pkg::NUM_CHAN; c++) begin
         ge[c] = rem_ff[c] >= dsh_ff;
      end
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(rmcb_pkg::MEAN_W - 1);
         dsh_in  = SUM_W'({divisor, {(rmcb_pkg::MEAN_W - 1){1'b0}}});
         rem_in  = dividend;
      end else if (run_ff) begin
         run_in  = step_ff != '0;
         step_in = step_ff - STEP_W'(1);
         dsh_in  = dsh_ff >> 1;
         for (int c = 0; c < rmcb_pkg::NUM_CHAN; c++) begin
            rem_in[c]  = ge[c] ? rem_ff[c] - dsh_ff : rem_ff[c];
            quot_in[c] = {quot_ff[c][rmcb_pkg::MEAN_W-2:0], ge[c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      dsh_ff  <= dsh_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = run_ff && (step_ff == '0);
   assign quotient = quot_ff;

endmodule

FILE: rtl/core/rmcb_checker.sv
// Port-level assertions for the region mean color box classifier and their bind.
module rmcb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rmcb_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed or vanished.");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("Request accepted right after a region was closed.");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("Result appeared while pixels were being accepted.");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.color_class <= rmcb_pkg::CLASS_NONE)
      else $error("Result carries an undefined class code.");

endmodule

bind region_mean_color_box_classifier rmcb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.data.last_pixel),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
